FILE: rtl/esc_pkg.sv
// Shared types and constants for the elevator scan controller.
// Holds the transfer payload structs, command and heading codes, and floor helpers.
// Depends on nothing; every other file imports it.
package esc_pkg;

  localparam int FLOOR_COUNT = 16;
  localparam int START_LEVEL = 1;
  localparam int FLOOR_W     = 5;
  localparam int LVL_W       = 7;
  localparam int IDX_W       = (FLOOR_COUNT > 2) ? $clog2(FLOOR_COUNT) : 1;

  typedef logic [LVL_W-1:0] lvl_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_STOP = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    HEAD_STAY = 2'd0,
    HEAD_UP   = 2'd1,
    HEAD_DOWN = 2'd2
  } head_t;

  typedef struct packed {
    logic               kind;
    logic [FLOOR_W-1:0] floor;
  } in_t;

  typedef struct packed {
    cmd_t               command;
    logic [FLOOR_W-1:0] current_floor;
    logic [FLOOR_W-1:0] target_floor;
    head_t              direction;
    logic               busy_res;
  } out_t;

  function automatic logic in_range(input lvl_t f);
    return (f >= lvl_t'(1)) && (f <= lvl_t'(FLOOR_COUNT));
  endfunction

  function automatic idx_t bit_idx(input lvl_t f);
    lvl_t d;
    d = f - lvl_t'(1);
    return d[IDX_W-1:0];
  endfunction

endpackage

FILE: rtl/elevator_scan_controller_unit.sv
// Elevator scan controller: one result transfer for each accepted event transfer.
// A press or an advance runs a target scan, which walks the request bitmap one floor a
// cycle: at most FLOOR_COUNT + 1 probes per scan. An arrival adds a second scan. The
// input is not ready while an event is being worked on; a finished result waits in the
// output register while the next event is accepted. Depends on esc_pkg.
module elevator_scan_controller_unit
  import esc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_RESOLVE,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    P_PRESS,
    P_ADV,
    P_ARRIVE
  } purpose_t;

  state_t                 state_r, state_nxt;
  purpose_t               purpose_r, purpose_nxt;
  lvl_t                   fl_r, fl_nxt;
  logic [FLOOR_COUNT-1:0] requested_r, requested_nxt;
  lvl_t                   cabin_r, cabin_nxt;
  lvl_t                   goal_r, goal_nxt;
  head_t                  heading_r, heading_nxt;
  head_t                  prev_r, prev_nxt;
  logic                   active_r, active_nxt;
  lvl_t                   ptr_r, ptr_nxt;
  head_t                  scan_dir_r, scan_dir_nxt;
  logic                   pass_r, pass_nxt;
  logic                   found_r, found_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_t                   out_data_r, out_data_nxt;

  logic hit;
  logic at_edge;
  lvl_t goal_cand;
  logic go_up;
  logic go_down;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign hit       = in_range(ptr_r) && requested_r[bit_idx(ptr_r)];
  assign at_edge   = (scan_dir_r == HEAD_DOWN) ? (ptr_r == lvl_t'(1))
                                               : (ptr_r == lvl_t'(FLOOR_COUNT));
  assign goal_cand = ((purpose_r == P_PRESS) && !found_r) ? fl_r : ptr_r;
  assign go_up     = goal_cand > cabin_r;
  assign go_down   = goal_cand < cabin_r;

  always_comb begin
    state_nxt     = state_r;
    purpose_nxt   = purpose_r;
    fl_nxt        = fl_r;
    requested_nxt = requested_r;
    cabin_nxt     = cabin_r;
    goal_nxt      = goal_r;
    heading_nxt   = heading_r;
    prev_nxt      = prev_r;
    active_nxt    = active_r;
    ptr_nxt       = ptr_r;
    scan_dir_nxt  = scan_dir_r;
    pass_nxt      = pass_r;
    found_nxt     = found_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          fl_nxt = lvl_t'(in_data.floor);
          if (!in_data.kind) begin
            if (in_range(lvl_t'(in_data.floor))) begin
              active_nxt = 1'b1;
              requested_nxt[bit_idx(lvl_t'(in_data.floor))] = 1'b1;
              purpose_nxt = P_PRESS;
              state_nxt = S_START;
            end else begin
              cmd_nxt = CMD_NONE;
              state_nxt = S_DONE;
            end
          end else begin
            active_nxt = 1'b1;
            purpose_nxt = P_ADV;
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        ptr_nxt   = cabin_r;
        pass_nxt  = 1'b0;
        found_nxt = 1'b0;
        if (heading_r != HEAD_STAY) begin
          scan_dir_nxt = heading_r;
        end else if (prev_r == HEAD_STAY) begin
          scan_dir_nxt = HEAD_UP;
        end else begin
          scan_dir_nxt = prev_r;
        end
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (hit) begin
          found_nxt = 1'b1;
          state_nxt = S_RESOLVE;
        end else if (in_range(ptr_r) && !at_edge) begin
          ptr_nxt = (scan_dir_r == HEAD_DOWN) ? ptr_r - lvl_t'(1) : ptr_r + lvl_t'(1);
        end else if (!pass_r) begin
          pass_nxt     = 1'b1;
          ptr_nxt      = cabin_r;
          scan_dir_nxt = (scan_dir_r == HEAD_UP) ? HEAD_DOWN : HEAD_UP;
        end else begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (purpose_r == P_ARRIVE) begin
          if (found_r) begin
            goal_nxt = ptr_r;
          end else begin
            active_nxt = 1'b0;
          end
          cmd_nxt   = CMD_STOP;
          state_nxt = S_DONE;
        end else if ((purpose_r == P_ADV) && !found_r) begin
          active_nxt = 1'b0;
          cmd_nxt    = CMD_NONE;
          state_nxt  = S_DONE;
        end else begin
          goal_nxt = goal_cand;
          if (go_up || go_down) begin
            heading_nxt = go_up ? HEAD_UP : HEAD_DOWN;
            if (purpose_r == P_ADV) begin
              cabin_nxt = go_up ? cabin_r + lvl_t'(1) : cabin_r - lvl_t'(1);
            end
            cmd_nxt   = CMD_MOVE;
            state_nxt = S_DONE;
          end else begin
            prev_nxt    = heading_r;
            heading_nxt = HEAD_STAY;
            cabin_nxt   = goal_cand;
            if (in_range(goal_cand)) begin
              requested_nxt[bit_idx(goal_cand)] = 1'b0;
            end
            purpose_nxt = P_ARRIVE;
            state_nxt   = S_START;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.command       = cmd_r;
          out_data_nxt.current_floor = cabin_r[FLOOR_W-1:0];
          out_data_nxt.target_floor  = goal_r[FLOOR_W-1:0];
          out_data_nxt.direction     = heading_r;
          out_data_nxt.busy_res      = active_r;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      requested_r <= '0;
      cabin_r     <= lvl_t'(START_LEVEL);
      goal_r      <= lvl_t'(START_LEVEL);
      heading_r   <= HEAD_STAY;
      prev_r      <= HEAD_STAY;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      requested_r <= requested_nxt;
      cabin_r     <= cabin_nxt;
      goal_r      <= goal_nxt;
      heading_r   <= heading_nxt;
      prev_r      <= prev_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
    purpose_r  <= purpose_nxt;
    fl_r       <= fl_nxt;
    ptr_r      <= ptr_nxt;
    scan_dir_r <= scan_dir_nxt;
    pass_r     <= pass_nxt;
    found_r    <= found_nxt;
    cmd_r      <= cmd_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: rtl/esc_checker.sv
// Port-level checker for the elevator scan controller, bound to the top level.
// Depends on esc_pkg and elevator_scan_controller_unit.
module esc_checker
  import esc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result changed or dropped before its transfer.");

  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Input stayed ready right after a transfer.");

  a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.command == CMD_NONE) || (out_data.command == CMD_MOVE)
                  || (out_data.command == CMD_STOP))
    else $error("Result carries an undefined command.");

  a_stop_stays: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.command == CMD_STOP) |-> out_data.direction == HEAD_STAY)
    else $error("Stop command reported with a moving direction.");

  a_move_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.command == CMD_MOVE)
      |-> out_data.busy_res && (out_data.direction != HEAD_STAY))
    else $error("Move command reported while idle or without a direction.");

endmodule

bind elevator_scan_controller_unit esc_checker u_esc_checker (.*);

FILE: bench/elevator_scan_controller_unit_tb.sv
// Self-checking bench for the elevator scan controller: floor presses and cabin advances
// go in, and every result transfer is checked against a scan scheduler kept in the bench.
// Depends on esc_pkg and elevator_scan_controller_unit.
`timescale 1ns / 100ps

module elevator_scan_controller_unit_tb;
  import esc_pkg::*;

  localparam int SCAN_LATENCY = 4 * FLOOR_COUNT + 8;
  localparam int DRAIN_LIMIT  = 20000;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  logic [FLOOR_COUNT-1:0] req_map;
  int    cab_lvl;
  int    goal_lvl;
  head_t cur_head;
  head_t last_head;
  logic  busy;

  out_t  expected_reports[$];
  int    send_gap_pct  = 0;
  int    recv_stall_pct = 0;
  int    errors        = 0;
  int    n_presses     = 0;
  int    n_advances    = 0;
  int    n_ignored     = 0;
  int    n_results     = 0;
  int    n_stops       = 0;

  elevator_scan_controller_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void reset_scheduler();
    req_map   = '0;
    cab_lvl   = START_LEVEL;
    goal_lvl  = START_LEVEL;
    cur_head  = HEAD_STAY;
    last_head = HEAD_STAY;
    busy      = 1'b0;
  endfunction

  function automatic bit scan_requests(head_t dir, output int hit);
    int lvl;
    int stride;
    stride = (dir == HEAD_DOWN) ? -1 : 1;
    lvl = cab_lvl;
    hit = 0;
    while (lvl >= 1 && lvl <= FLOOR_COUNT) begin
      if (req_map[lvl-1]) begin
        hit = lvl;
        return 1'b1;
      end
      lvl += stride;
    end
    return 1'b0;
  endfunction

  function automatic bit find_goal(output int hit);
    head_t dir;
    if (cur_head != HEAD_STAY) begin
      dir = cur_head;
    end else begin
      dir = (last_head == HEAD_STAY) ? HEAD_UP : last_head;
    end
    if (scan_requests(dir, hit)) return 1'b1;
    return scan_requests((dir == HEAD_UP) ? HEAD_DOWN : HEAD_UP, hit);
  endfunction

  function automatic void pick_heading();
    if (goal_lvl > cab_lvl) begin
      cur_head = HEAD_UP;
    end else if (goal_lvl < cab_lvl) begin
      cur_head = HEAD_DOWN;
    end else begin
      last_head = cur_head;
      cur_head  = HEAD_STAY;
    end
  endfunction

  function automatic cmd_t serve_goal();
    int nxt;
    cab_lvl = goal_lvl;
    if (goal_lvl >= 1 && goal_lvl <= FLOOR_COUNT) req_map[goal_lvl-1] = 1'b0;
    if (find_goal(nxt)) begin
      goal_lvl = nxt;
    end else begin
      busy = 1'b0;
    end
    return CMD_STOP;
  endfunction

  function automatic out_t step_scheduler(in_t ev);
    int   hit;
    int   lvl;
    cmd_t cmd;
    out_t res;
    cmd = CMD_NONE;
    lvl = int'(ev.floor);
    if (ev.kind == 1'b0) begin
      if (lvl >= 1 && lvl <= FLOOR_COUNT) begin
        busy = 1'b1;
        req_map[lvl-1] = 1'b1;
        if (find_goal(hit)) begin
          goal_lvl = hit;
        end else begin
          goal_lvl = lvl;
        end
        pick_heading();
        cmd = (cur_head == HEAD_STAY) ? serve_goal() : CMD_MOVE;
      end
    end else begin
      busy = 1'b1;
      if (!find_goal(hit)) begin
        busy = 1'b0;
      end else begin
        goal_lvl = hit;
        pick_heading();
        if (cur_head != HEAD_STAY) begin
          cab_lvl = (cur_head == HEAD_UP) ? cab_lvl + 1 : cab_lvl - 1;
          cmd = CMD_MOVE;
        end else begin
          cmd = serve_goal();
        end
      end
    end
    res.command       = cmd;
    res.current_floor = cab_lvl[FLOOR_W-1:0];
    res.target_floor  = goal_lvl[FLOOR_W-1:0];
    res.direction     = cur_head;
    res.busy_res      = busy;
    return res;
  endfunction

  task automatic send_event(logic kind, logic [FLOOR_W-1:0] lvl);
    in_t  ev;
    out_t want;
    ev.kind  = kind;
    ev.floor = lvl;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = step_scheduler(ev);
    expected_reports = {expected_reports, want};
    if (kind) begin
      n_advances++;
    end else if (lvl >= 1 && lvl <= FLOOR_COUNT) begin
      n_presses++;
    end else begin
      n_ignored++;
    end
  endtask

  task automatic press(int lvl);
    send_event(1'b0, lvl[FLOOR_W-1:0]);
  endtask

  task automatic advance();
    send_event(1'b1, FLOOR_W'($urandom_range(31)));
  endtask

  task automatic test_corner_presses();
    advance();
    press(START_LEVEL);
    press(0);
    press(FLOOR_COUNT + 1);
    press(31);
  endtask

  task automatic test_scan_ride();
    press(5);
    press(3);
    repeat (3) advance();
    press(2);
    repeat (3) advance();
    repeat (4) advance();
    advance();
    press(FLOOR_COUNT);
  endtask

  task automatic test_random_traffic(int count, int gap_pct, int stall_pct);
    int sent;
    int roll;
    int off;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        off = $urandom_range(15);
        press((off == 0) ? 0 : FLOOR_COUNT + off);
        sent++;
      end else if (roll < 40) begin
        press($urandom_range(FLOOR_COUNT, 1));
        sent++;
      end else begin
        advance();
        sent++;
      end
    end
  endtask

  task automatic check_field(string name, logic [FLOOR_W-1:0] want, logic [FLOOR_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: result transfer with none expected, got %p", $time, out_data);
      end else begin
        want = expected_reports.pop_front();
        n_results++;
        if (want.command == CMD_STOP) n_stops++;
        check_field("command", FLOOR_W'(want.command), FLOOR_W'(out_data.command));
        check_field("current_floor", want.current_floor, out_data.current_floor);
        check_field("target_floor", want.target_floor, out_data.target_floor);
        check_field("direction", FLOOR_W'(want.direction), FLOOR_W'(out_data.direction));
        check_field("busy_res", FLOOR_W'(want.busy_res), FLOOR_W'(out_data.busy_res));
      end
    end
  end

  initial begin
    int waited;
    reset_scheduler();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_presses();
    test_scan_ride();
    test_random_traffic(450, 16, 48);
    test_random_traffic(450, 48, 16);
    test_random_traffic(430, 0, 0);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SCAN_LATENCY) @(posedge clk);
    if (expected_reports.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived, next expected %p",
               $time, expected_reports.size(), expected_reports[0]);
    end
    $display("Sent %0d floor presses, %0d cabin advances and %0d out-of-range presses.",
             n_presses, n_advances, n_ignored);
    $display("Checked %0d result transfers, %0d of them stops, with %0d mismatches.",
             n_results, n_stops, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
